// ===== hw/rtl/msfc_pkg.sv =====
// ----------------------------------------------------------------------------
// Message-send frame checker package
// Shared widths, constants, codes and the record passed from the parser to
// the result stage.
// ----------------------------------------------------------------------------
package msfc_pkg;

  localparam int COUNT_WIDTH_DEFAULT = 10;
  localparam int QUEUE_DEPTH_DEFAULT = 2;
  localparam int LEN_WIDTH           = 10;
  localparam int BYTE_WIDTH          = 8;
  localparam int VERDICT_WIDTH       = 4;
  localparam int APB_DATA_WIDTH      = 32;
  localparam int APB_ADDR_WIDTH      = 2;

  localparam logic [APB_ADDR_WIDTH-1:0] ADDR_MAX_FRAME_LEN  = 2'd0;
  localparam logic [LEN_WIDTH-1:0]      MAX_FRAME_LEN_RESET = 10'd512;

  localparam logic [BYTE_WIDTH-1:0] CHAR_NUL      = 8'h00;
  localparam logic [BYTE_WIDTH-1:0] CHAR_A        = 8'h41;
  localparam logic [BYTE_WIDTH-1:0] CHAR_B        = 8'h42;
  localparam logic [BYTE_WIDTH-1:0] CHAR_UPPER_Z  = 8'h5A;
  localparam logic [BYTE_WIDTH-1:0] CHAR_LOWER_A  = 8'h61;
  localparam logic [BYTE_WIDTH-1:0] CHAR_LOWER_Z  = 8'h7A;
  localparam logic [BYTE_WIDTH-1:0] PRINTABLE_LO  = 8'h20;
  localparam logic [BYTE_WIDTH-1:0] PRINTABLE_HI  = 8'h7E;

  localparam logic [2:0] FIELD_RECIPIENT = 3'd0;
  localparam logic [2:0] FIELD_MESSAGE   = 3'd2;
  localparam logic [2:0] FIELD_SENDER    = 3'd3;
  localparam logic [2:0] FIELDS_A        = 3'd3;
  localparam logic [2:0] FIELDS_B        = 3'd7;

  typedef enum logic [1:0] {
    PH_IDLE    = 2'd0,
    PH_PARSE   = 2'd1,
    PH_DISCARD = 2'd2
  } phase_t;

  typedef enum logic [1:0] {
    KIND_FINAL       = 2'd0,
    KIND_BAD_VERSION = 2'd1,
    KIND_TOO_LONG    = 2'd2,
    KIND_TRUNCATED   = 2'd3
  } kind_t;

  typedef enum logic [VERDICT_WIDTH-1:0] {
    VERDICT_USER          = 4'd0,
    VERDICT_CHANNEL       = 4'd1,
    VERDICT_BAD_VERSION   = 4'd2,
    VERDICT_TOO_LONG      = 4'd3,
    VERDICT_TRUNCATED     = 4'd4,
    VERDICT_EMPTY_MESSAGE = 4'd5,
    VERDICT_BAD_CHARS     = 4'd6,
    VERDICT_EMPTY_SENDER  = 4'd7,
    VERDICT_NO_RECIPIENT  = 4'd8
  } verdict_t;

  typedef struct packed {
    kind_t                kind;
    logic                 version_b;
    logic [LEN_WIDTH-1:0] recipient_length;
    logic [LEN_WIDTH-1:0] message_length;
    logic [LEN_WIDTH-1:0] sender_length;
    logic                 msg_unprintable;
    logic                 recip_starts_alpha;
  } record_t;

endpackage

// ===== hw/rtl/msfc_if.sv =====
// ----------------------------------------------------------------------------
// Message-send frame checker channels
// Valid/ready channels for incoming frame bytes and outgoing verdicts.
// ----------------------------------------------------------------------------
interface msfc_byte_if;
  logic                             valid;
  logic                             ready;
  logic [msfc_pkg::BYTE_WIDTH-1:0]  data_byte;
  logic                             frame_end;

  modport source (output valid, output data_byte, output frame_end, input ready);
  modport sink   (input valid, input data_byte, input frame_end, output ready);
endinterface

interface msfc_verdict_if;
  logic                               valid;
  logic                               ready;
  logic [msfc_pkg::VERDICT_WIDTH-1:0] verdict;
  logic                               version_b;
  logic [msfc_pkg::LEN_WIDTH-1:0]     recipient_length;
  logic [msfc_pkg::LEN_WIDTH-1:0]     message_length;
  logic [msfc_pkg::LEN_WIDTH-1:0]     sender_length;

  modport source (output valid, output verdict, output version_b, output recipient_length,
                  output message_length, output sender_length, input ready);
  modport sink   (input valid, input verdict, input version_b, input recipient_length,
                  input message_length, input sender_length, output ready);
endinterface

// ===== hw/rtl/msfc_front.sv =====
// ----------------------------------------------------------------------------
// Message-send frame checker parser
// Accepts frame bytes, tracks field counters and flags, and pushes a record
// into the queue whenever a byte ends the checking of a frame.
// ----------------------------------------------------------------------------
module msfc_front #(
  parameter int COUNT_WIDTH = msfc_pkg::COUNT_WIDTH_DEFAULT
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic [msfc_pkg::LEN_WIDTH-1:0] max_frame_len,
  msfc_byte_if.sink                      frame_bytes,
  input  logic                           queue_full,
  output logic                           push,
  output msfc_pkg::record_t              rec
);

  localparam int LenW = msfc_pkg::LEN_WIDTH;
  localparam int CmpW = (COUNT_WIDTH > LenW) ? COUNT_WIDTH : LenW;
  localparam logic [COUNT_WIDTH-1:0] CntMax = '1;
  localparam logic [COUNT_WIDTH-1:0] CntOne = COUNT_WIDTH'(1);

  msfc_pkg::phase_t       phase, phase_next;
  logic                   version_flag, version_flag_next;
  logic [2:0]             field_index, field_index_next;
  logic [COUNT_WIDTH-1:0] byte_count, byte_count_next;
  logic [COUNT_WIDTH-1:0] recip_len, recip_len_next;
  logic [COUNT_WIDTH-1:0] msg_len, msg_len_next;
  logic [COUNT_WIDTH-1:0] sender_len, sender_len_next;
  logic                   msg_unprintable, msg_unprintable_next;
  logic                   recip_starts_alpha, recip_starts_alpha_next;

  logic                             accept;
  logic [msfc_pkg::BYTE_WIDTH-1:0]  b;
  logic                             fend;
  logic [2:0]                       fields_wanted;
  logic                             is_alpha;
  logic                             is_printable;
  logic                             too_long;
  logic                             final_hit;
  msfc_pkg::kind_t                  kind;

  assign frame_bytes.ready = ~queue_full;
  assign accept = frame_bytes.valid & frame_bytes.ready;
  assign b      = frame_bytes.data_byte;
  assign fend   = frame_bytes.frame_end;

  assign fields_wanted = version_flag ? msfc_pkg::FIELDS_B : msfc_pkg::FIELDS_A;
  assign is_alpha = ((b >= msfc_pkg::CHAR_A) && (b <= msfc_pkg::CHAR_UPPER_Z)) ||
                    ((b >= msfc_pkg::CHAR_LOWER_A) && (b <= msfc_pkg::CHAR_LOWER_Z));
  assign is_printable = (b >= msfc_pkg::PRINTABLE_LO) && (b <= msfc_pkg::PRINTABLE_HI);
  assign too_long = CmpW'(byte_count) >= CmpW'(max_frame_len);

  always_ff @(posedge clk) begin
    if (rst) begin
      phase              <= msfc_pkg::PH_IDLE;
      version_flag       <= 1'b0;
      field_index        <= '0;
      byte_count         <= '0;
      recip_len          <= '0;
      msg_len            <= '0;
      sender_len         <= '0;
      msg_unprintable    <= 1'b0;
      recip_starts_alpha <= 1'b0;
    end else begin
      phase              <= phase_next;
      version_flag       <= version_flag_next;
      field_index        <= field_index_next;
      byte_count         <= byte_count_next;
      recip_len          <= recip_len_next;
      msg_len            <= msg_len_next;
      sender_len         <= sender_len_next;
      msg_unprintable    <= msg_unprintable_next;
      recip_starts_alpha <= recip_starts_alpha_next;
    end
  end

  always_comb begin
    phase_next              = phase;
    version_flag_next       = version_flag;
    field_index_next        = field_index;
    byte_count_next         = byte_count;
    recip_len_next          = recip_len;
    msg_len_next            = msg_len;
    sender_len_next         = sender_len;
    msg_unprintable_next    = msg_unprintable;
    recip_starts_alpha_next = recip_starts_alpha;
    push                    = 1'b0;
    kind                    = msfc_pkg::KIND_FINAL;
    final_hit               = 1'b0;

    if (accept) begin
      case (phase)
        msfc_pkg::PH_DISCARD: begin
          if (fend) begin
            phase_next = msfc_pkg::PH_IDLE;
          end
        end
        msfc_pkg::PH_IDLE: begin
          version_flag_next       = 1'b0;
          field_index_next        = '0;
          byte_count_next         = CntOne;
          recip_len_next          = '0;
          msg_len_next            = '0;
          sender_len_next         = '0;
          msg_unprintable_next    = 1'b0;
          recip_starts_alpha_next = 1'b0;
          if ((b != msfc_pkg::CHAR_A) && (b != msfc_pkg::CHAR_B)) begin
            push       = 1'b1;
            kind       = msfc_pkg::KIND_BAD_VERSION;
            phase_next = fend ? msfc_pkg::PH_IDLE : msfc_pkg::PH_DISCARD;
          end else begin
            version_flag_next = (b == msfc_pkg::CHAR_B);
            if (fend) begin
              push       = 1'b1;
              kind       = msfc_pkg::KIND_TRUNCATED;
              phase_next = msfc_pkg::PH_IDLE;
            end else begin
              phase_next = msfc_pkg::PH_PARSE;
            end
          end
        end
        msfc_pkg::PH_PARSE: begin
          if (too_long) begin
            push       = 1'b1;
            kind       = msfc_pkg::KIND_TOO_LONG;
            phase_next = fend ? msfc_pkg::PH_IDLE : msfc_pkg::PH_DISCARD;
          end else begin
            byte_count_next = (byte_count == CntMax) ? byte_count : byte_count + CntOne;
            if (b == msfc_pkg::CHAR_NUL) begin
              field_index_next = field_index + 3'd1;
              final_hit        = (field_index_next >= fields_wanted);
            end else if (field_index == msfc_pkg::FIELD_RECIPIENT) begin
              if (recip_len == '0) begin
                recip_starts_alpha_next = is_alpha;
              end
              recip_len_next = (recip_len == CntMax) ? recip_len : recip_len + CntOne;
            end else if (field_index == msfc_pkg::FIELD_MESSAGE) begin
              if (!is_printable) begin
                msg_unprintable_next = 1'b1;
              end
              msg_len_next = (msg_len == CntMax) ? msg_len : msg_len + CntOne;
            end else if ((field_index == msfc_pkg::FIELD_SENDER) && version_flag) begin
              sender_len_next = (sender_len == CntMax) ? sender_len : sender_len + CntOne;
            end
            if (final_hit) begin
              push       = 1'b1;
              kind       = msfc_pkg::KIND_FINAL;
              phase_next = fend ? msfc_pkg::PH_IDLE : msfc_pkg::PH_DISCARD;
            end else if (fend) begin
              push       = 1'b1;
              kind       = msfc_pkg::KIND_TRUNCATED;
              phase_next = msfc_pkg::PH_IDLE;
            end
          end
        end
        default: begin
          phase_next = msfc_pkg::PH_IDLE;
        end
      endcase
    end
  end

  always_comb begin
    rec.kind               = kind;
    rec.version_b          = version_flag_next;
    rec.recipient_length   = LenW'(recip_len_next);
    rec.message_length     = LenW'(msg_len_next);
    rec.sender_length      = LenW'(sender_len_next);
    rec.msg_unprintable    = msg_unprintable_next;
    rec.recip_starts_alpha = recip_starts_alpha_next;
  end

endmodule

// ===== hw/rtl/msfc_queue.sv =====
// ----------------------------------------------------------------------------
// Message-send frame checker record queue
// A short first-in first-out queue of records between the parser and the
// result stage.
// ----------------------------------------------------------------------------
module msfc_queue #(
  parameter int DEPTH = msfc_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  msfc_pkg::record_t push_data,
  input  logic              pop,
  output msfc_pkg::record_t head,
  output logic              head_valid,
  output logic              full
);

  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(DEPTH - 1);

  msfc_pkg::record_t entries [DEPTH];
  logic [PtrW-1:0]   wr_ptr, rd_ptr;
  logic [CntW-1:0]   count;
  logic              do_push, do_pop;

  assign full       = (count == CntW'(DEPTH));
  assign head_valid = (count != '0);
  assign head       = entries[rd_ptr];
  assign do_push    = push & ~full;
  assign do_pop     = pop & head_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LastPtr) ? '0 : wr_ptr + PtrW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LastPtr) ? '0 : rd_ptr + PtrW'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CntW'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CntW'(1);
      end
    end
  end

endmodule

// ===== hw/rtl/msfc_back.sv =====
// ----------------------------------------------------------------------------
// Message-send frame checker result stage
// Turns the record at the head of the queue into a verdict and holds it in
// the output register until the receiver takes the transfer.
// ----------------------------------------------------------------------------
module msfc_back (
  input  logic              clk,
  input  logic              rst,
  input  logic              head_valid,
  input  msfc_pkg::record_t head,
  output logic              pop,
  msfc_verdict_if.source    verdicts
);

  msfc_pkg::verdict_t verdict_next;
  logic               out_valid;
  logic               load;

  always_comb begin
    case (head.kind)
      msfc_pkg::KIND_BAD_VERSION: verdict_next = msfc_pkg::VERDICT_BAD_VERSION;
      msfc_pkg::KIND_TOO_LONG:    verdict_next = msfc_pkg::VERDICT_TOO_LONG;
      msfc_pkg::KIND_TRUNCATED:   verdict_next = msfc_pkg::VERDICT_TRUNCATED;
      msfc_pkg::KIND_FINAL: begin
        if (head.message_length == '0) begin
          verdict_next = msfc_pkg::VERDICT_EMPTY_MESSAGE;
        end else if (head.msg_unprintable) begin
          verdict_next = msfc_pkg::VERDICT_BAD_CHARS;
        end else if (head.sender_length == '0) begin
          verdict_next = msfc_pkg::VERDICT_EMPTY_SENDER;
        end else if (head.recipient_length == '0) begin
          verdict_next = msfc_pkg::VERDICT_NO_RECIPIENT;
        end else if (head.recip_starts_alpha) begin
          verdict_next = msfc_pkg::VERDICT_USER;
        end else begin
          verdict_next = msfc_pkg::VERDICT_CHANNEL;
        end
      end
      default: verdict_next = msfc_pkg::VERDICT_TRUNCATED;
    endcase
  end

  assign load = ~out_valid | verdicts.ready;
  assign pop  = head_valid & load;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= head_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      verdicts.verdict          <= verdict_next;
      verdicts.version_b        <= head.version_b;
      verdicts.recipient_length <= head.recipient_length;
      verdicts.message_length   <= head.message_length;
      verdicts.sender_length    <= head.sender_length;
    end
  end

  assign verdicts.valid = out_valid;

endmodule

// ===== hw/rtl/message_send_frame_checker.sv =====
// ----------------------------------------------------------------------------
// Message-send frame checker
// Checks message-send frames byte by byte and gives one verdict per frame.
// ----------------------------------------------------------------------------
// Frame bytes arrive on frame_bytes, one byte per transfer, with frame_end
// marking the last byte of a datagram. Each frame gives at most one transfer
// on verdicts: the verdict code, the version flag and the recipient, message
// and sender lengths. Bytes after a verdict are dropped up to frame end.
// The parser takes one byte per cycle while the queue is not full; a byte
// that settles a verdict pushes a record into the record queue (two entries
// by default), and the result stage loads the record at the queue head into
// the output register once it is empty or its transfer is taken.
// When the receiver stalls, the output register holds its transfer and the
// queue absorbs further records; frame_bytes.ready falls only when the queue
// is full. Reset clears the parser, the queue and the output valid flag, and
// sets max_frame_len to 512. The user must write max_frame_len through the
// APB port at address 0 only while no frame is in progress; the block itself
// does not enforce this.
// ----------------------------------------------------------------------------
module message_send_frame_checker #(
  parameter int COUNT_WIDTH = msfc_pkg::COUNT_WIDTH_DEFAULT,
  parameter int QUEUE_DEPTH = msfc_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [msfc_pkg::APB_ADDR_WIDTH-1:0] paddr,
  input  logic [msfc_pkg::APB_DATA_WIDTH-1:0] pwdata,
  output logic [msfc_pkg::APB_DATA_WIDTH-1:0] prdata,
  output logic                                pready,
  msfc_byte_if.sink                           frame_bytes,
  msfc_verdict_if.source                      verdicts
);

  localparam int LenW = msfc_pkg::LEN_WIDTH;

  logic [LenW-1:0]   max_frame_len;
  logic              reg_write;
  logic              push, pop, head_valid, queue_full;
  msfc_pkg::record_t rec, head;

  assign pready    = 1'b1;
  assign reg_write = psel & penable & pwrite & pready & (paddr == msfc_pkg::ADDR_MAX_FRAME_LEN);
  assign prdata    = (paddr == msfc_pkg::ADDR_MAX_FRAME_LEN) ?
                     msfc_pkg::APB_DATA_WIDTH'(max_frame_len) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_frame_len <= msfc_pkg::MAX_FRAME_LEN_RESET;
    end else if (reg_write) begin
      max_frame_len <= pwdata[LenW-1:0];
    end
  end

  msfc_front #(
    .COUNT_WIDTH(COUNT_WIDTH)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .max_frame_len(max_frame_len),
    .frame_bytes  (frame_bytes),
    .queue_full   (queue_full),
    .push         (push),
    .rec          (rec)
  );

  msfc_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (rec),
    .pop       (pop),
    .head      (head),
    .head_valid(head_valid),
    .full      (queue_full)
  );

  msfc_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head_valid(head_valid),
    .head      (head),
    .pop       (pop),
    .verdicts  (verdicts)
  );

endmodule

// ===== hw/rtl/msfc_checker.sv =====
// ----------------------------------------------------------------------------
// Message-send frame checker port checks
// Concurrent assertions on the verdict channel, bound to the top level.
// ----------------------------------------------------------------------------
module msfc_checker (
  input logic                               clk,
  input logic                               rst,
  input logic                               out_valid,
  input logic                               out_ready,
  input logic [msfc_pkg::VERDICT_WIDTH-1:0] verdict,
  input logic                               version_b,
  input logic [msfc_pkg::LEN_WIDTH-1:0]     recipient_length,
  input logic [msfc_pkg::LEN_WIDTH-1:0]     message_length,
  input logic [msfc_pkg::LEN_WIDTH-1:0]     sender_length
);

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(verdict) && $stable(version_b) &&
      $stable(recipient_length) && $stable(message_length) && $stable(sender_length))
    else $error("verdict transfer changed while stalled");

  a_code_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> verdict <= msfc_pkg::VERDICT_NO_RECIPIENT)
    else $error("verdict code out of range");

  a_bad_version_empty: assert property (@(posedge clk) disable iff (rst)
    out_valid && verdict == msfc_pkg::VERDICT_BAD_VERSION |->
      !version_b && recipient_length == '0 && message_length == '0 && sender_length == '0)
    else $error("bad version verdict carries frame data");

  a_route_complete: assert property (@(posedge clk) disable iff (rst)
    out_valid && (verdict == msfc_pkg::VERDICT_USER || verdict == msfc_pkg::VERDICT_CHANNEL)
      |-> version_b && recipient_length != '0 && message_length != '0 &&
          sender_length != '0)
    else $error("route verdict on an incomplete frame");

  a_version_a_no_sender: assert property (@(posedge clk) disable iff (rst)
    out_valid && !version_b |-> sender_length == '0)
    else $error("sender length reported for a version A frame");

endmodule

bind message_send_frame_checker msfc_checker u_msfc_checker (
  .clk             (clk),
  .rst             (rst),
  .out_valid       (verdicts.valid),
  .out_ready       (verdicts.ready),
  .verdict         (verdicts.verdict),
  .version_b       (verdicts.version_b),
  .recipient_length(verdicts.recipient_length),
  .message_length  (verdicts.message_length),
  .sender_length   (verdicts.sender_length)
);
